/* rtl/core/hbil_pkg.sv */
// Shared types and constants for the halt-bounded idle-loop filter.
// No dependencies; every other file in rtl/core imports this package.
package hbil_pkg;

  localparam int CAND_DEPTH = 32;
  localparam int CAND_AW    = (CAND_DEPTH > 1) ? $clog2(CAND_DEPTH) : 1;
  localparam int FILL_W     = $clog2(CAND_DEPTH + 1);

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  localparam logic [7:0] HALT_OPCODE_RST = 8'hF4;
  localparam logic [3:0] HALT_SIZE       = 4'h1;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;
  localparam logic PRIV_USER  = 1'b0;

  typedef enum logic {
    MODE_ACTIVE,
    MODE_CAND
  } mode_e;

  typedef enum logic [2:0] {
    CMD_PASS,       // emit record, last
    CMD_START,      // restart run with record at slot 0
    CMD_APPEND,     // add record to run
    CMD_DRAIN_EMIT, // emit run, then record as last
    CMD_FLUSH       // emit run, final entry last
  } cmd_op_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RD,
    B_WR,
    B_TAIL
  } back_state_e;

  typedef struct packed {
    logic [31:0] rref;
    logic [9:0]  rlen;
    logic        priv;
  } rec_t;

  typedef struct packed {
    cmd_op_e op;
    rec_t    rec;
  } cmd_t;

endpackage

/* rtl/core/hbil_front.sv */
// Front end: holds the halt opcode register, detects halts and turns accepted
// items into buffer commands. Depends on hbil_pkg.
module hbil_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             req_type_i,
  input  logic             privileged_i,
  input  logic [3:0]       instr_size_i,
  input  logic [7:0]       first_opcode_byte_i,
  input  logic [31:0]      record_ref_i,
  input  logic [9:0]       record_len_i,
  input  logic             q_full_i,
  output logic             cmd_push_o,
  output hbil_pkg::cmd_t   cmd_o
);
  import hbil_pkg::*;

  logic [7:0]        halt_q;
  mode_e             mode_q, mode_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              accept;
  logic              is_halt;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_halt    = (instr_size_i == HALT_SIZE) && (first_opcode_byte_i == halt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halt_q <= HALT_OPCODE_RST;
      mode_q <= MODE_ACTIVE;
      fill_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        halt_q <= cfg_wdata_i;
      end
      mode_q <= mode_d;
      fill_q <= fill_d;
    end
  end

  always_comb begin
    mode_d         = mode_q;
    fill_d         = fill_q;
    cmd_push_o     = 1'b0;
    cmd_o.op       = CMD_PASS;
    cmd_o.rec.rref = record_ref_i;
    cmd_o.rec.rlen = record_len_i;
    cmd_o.rec.priv = privileged_i;
    if (accept) begin
      if (req_type_i == REQ_FLUSH) begin
        // an empty buffer flushes to nothing, so no command is queued
        cmd_o.op   = CMD_FLUSH;
        cmd_push_o = (fill_q != '0);
        mode_d     = MODE_ACTIVE;
        fill_d     = '0;
      end else if (is_halt) begin
        cmd_o.op   = CMD_START;
        cmd_push_o = 1'b1;
        mode_d     = MODE_CAND;
        fill_d     = FILL_W'(1);
      end else begin
        case (mode_q)
          MODE_ACTIVE: begin
            cmd_o.op   = CMD_PASS;
            cmd_push_o = 1'b1;
          end
          MODE_CAND: begin
            cmd_push_o = 1'b1;
            if (privileged_i == PRIV_USER || fill_q >= FILL_W'(CAND_DEPTH)) begin
              cmd_o.op = CMD_DRAIN_EMIT;
              mode_d   = MODE_ACTIVE;
              fill_d   = '0;
            end else begin
              cmd_o.op = CMD_APPEND;
              fill_d   = fill_q + FILL_W'(1);
            end
          end
          default: begin
            mode_d = MODE_ACTIVE;
          end
        endcase
      end
    end
  end

endmodule

/* rtl/core/hbil_cmd_fifo.sv */
// Short command queue between the front end and the back end.
// Depends on hbil_pkg for the command type and depth.
module hbil_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hbil_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output hbil_pkg::cmd_t head_o
);
  import hbil_pkg::*;

  cmd_t               slot_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMDQ_CW-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CMDQ_CW'(CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [CMDQ_AW-1:0] ptr_inc(input logic [CMDQ_AW-1:0] p);
    return (p == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : p + CMDQ_AW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CMDQ_CW'(1);
        2'b01:   cnt_q <= cnt_q - CMDQ_CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/hbil_back.sv */
// Back end: candidate record store, drain sequencer and output register.
// Depends on hbil_pkg; executes commands from hbil_cmd_fifo in order.
module hbil_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  hbil_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [31:0]    out_record_ref_o,
  output logic [9:0]     out_record_len_o,
  output logic           out_privileged_o,
  output logic           last_o
);
  import hbil_pkg::*;

  rec_t               mem [CAND_DEPTH];
  rec_t               rd_data_q;
  logic               mem_we, mem_re;
  logic [CAND_AW-1:0] mem_waddr;

  back_state_e        state_q, state_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [CAND_AW-1:0] rd_idx_q, rd_idx_d;

  logic               out_valid_q, out_valid_d;
  rec_t               out_rec_q, out_rec_d;
  logic               out_last_q, out_last_d;
  logic               out_load;
  logic               slot_free;
  logic               rd_is_end;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign rd_is_end = (FILL_W'(rd_idx_q) + FILL_W'(1) == fill_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      fill_q      <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rec_q  <= out_rec_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= cmd_i.rec;
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_idx_q];
    end
  end

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    rd_idx_d   = rd_idx_q;
    cmd_pop_o  = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = '0;
    out_load   = 1'b0;
    out_rec_d  = cmd_i.rec;
    out_last_d = 1'b1;

    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            CMD_PASS: begin
              if (slot_free) begin
                out_load  = 1'b1;
                cmd_pop_o = 1'b1;
              end
            end
            CMD_START: begin
              mem_we    = 1'b1;
              fill_d    = FILL_W'(1);
              cmd_pop_o = 1'b1;
            end
            CMD_APPEND: begin
              mem_we    = 1'b1;
              mem_waddr = fill_q[CAND_AW-1:0];
              fill_d    = fill_q + FILL_W'(1);
              cmd_pop_o = 1'b1;
            end
            CMD_DRAIN_EMIT, CMD_FLUSH: begin
              rd_idx_d = '0;
              state_d  = B_RD;
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      B_RD: begin
        mem_re  = 1'b1;
        state_d = B_WR;
      end
      B_WR: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_rec_d  = rd_data_q;
          // on a flush the final buffered record closes the item
          out_last_d = (cmd_i.op == CMD_FLUSH) && rd_is_end;
          if (rd_is_end) begin
            fill_d = '0;
            if (cmd_i.op == CMD_FLUSH) begin
              cmd_pop_o = 1'b1;
              state_d   = B_IDLE;
            end else begin
              state_d = B_TAIL;
            end
          end else begin
            rd_idx_d = rd_idx_q + CAND_AW'(1);
            state_d  = B_RD;
          end
        end
      end
      B_TAIL: begin
        if (slot_free) begin
          out_load  = 1'b1;
          cmd_pop_o = 1'b1;
          state_d   = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_record_ref_o = out_rec_q.rref;
  assign out_record_len_o = out_rec_q.rlen;
  assign out_privileged_o = out_rec_q.priv;
  assign last_o           = out_last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(CAND_DEPTH))
    else $error("candidate fill above depth");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_WR) |-> (fill_q != '0))
    else $error("drain on empty buffer");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> cmd_valid_i)
    else $error("pop from empty command queue");

  a_rd_then_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_RD) |=> (state_q == B_WR))
    else $error("read not followed by write-out");

  a_drain_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != B_IDLE) |-> (cmd_valid_i &&
      (cmd_i.op == CMD_DRAIN_EMIT || cmd_i.op == CMD_FLUSH)))
    else $error("drain without drain command at head");

endmodule

/* rtl/core/halt_bounded_idle_loop_filter_unit.sv */
// Halt-bounded idle-loop filter, top level: front end, command queue, back end.
// Depends on hbil_pkg, hbil_front, hbil_cmd_fifo and hbil_back.

// Filters runs of kernel records that start at a one-byte halt instruction.
// A record that passes straight through goes via the command queue into the
// output register, and such records follow back to back while the output does
// not stall; buffering a record (halt or kernel record in a run) is one store
// write. Draining a run of buffered records picks up the command, then does one
// store read and one output load per record (set by the single read port of the
// candidate store), then loads the record that ends the run. A two-beat command
// queue lets the input keep moving while a drain or a stalled output holds the
// back end. The buffer holds 32 records; a kernel record that finds it full
// drains it.
// halt_opcode is written on the cfg channel (always ready) and should only
// change while the block is idle.
module halt_bounded_idle_loop_filter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic        privileged_i,
  input  logic [3:0]  instr_size_i,
  input  logic [7:0]  first_opcode_byte_i,
  input  logic [31:0] record_ref_i,
  input  logic [9:0]  record_len_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_record_ref_o,
  output logic [9:0]  out_record_len_o,
  output logic        out_privileged_o,
  output logic        last_o
);
  import hbil_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic push, q_full, q_valid, pop;

  assign cfg_ready_o = 1'b1;

  hbil_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .req_type_i          (req_type_i),
    .privileged_i        (privileged_i),
    .instr_size_i        (instr_size_i),
    .first_opcode_byte_i (first_opcode_byte_i),
    .record_ref_i        (record_ref_i),
    .record_len_i        (record_len_i),
    .q_full_i            (q_full),
    .cmd_push_o          (push),
    .cmd_o               (push_cmd)
  );

  hbil_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head_cmd)
  );

  hbil_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (q_valid),
    .cmd_i            (head_cmd),
    .cmd_pop_o        (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_record_ref_o (out_record_ref_o),
    .out_record_len_o (out_record_len_o),
    .out_privileged_o (out_privileged_o),
    .last_o           (last_o)
  );

endmodule
